>>> hw/rtl/grc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid ray caster package
// Types, fixed constants and small tables shared by the ray caster modules.
// ----------------------------------------------------------------------------
package grc_pkg;

    // Geometry of the map and of the fixed-point pixel format.
    localparam int CELL_SIZE  = 64;
    localparam int CELL_LOG   = 6;
    localparam int MAP_DIM    = 64;
    localparam int MAP_LOG    = 6;
    localparam int ANGLE_BITS = 12;
    localparam int FRAC       = 8;
    localparam int CELL_SHIFT = FRAC + CELL_LOG;
    localparam int CELL_PX    = CELL_SIZE << FRAC;
    localparam int ADDR_W     = 2 * MAP_LOG;

    // Working widths.
    localparam int POS_W   = 52;
    localparam int DD_W    = POS_W + 1;
    localparam int DIFF_W  = CELL_SHIFT + 2;
    localparam int TRIG_W  = 32;
    localparam int DIV_W   = DIFF_W + TRIG_W;
    localparam int KEY_W   = 25;
    localparam int RAD_W   = 2 * KEY_W;
    localparam int REM_W   = KEY_W + 2;

    // Rotation unit.
    localparam int CORDIC_ITERS = 28;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_GAIN  = 652032874;
    localparam int Q30_ONE      = 1073741824;

    // Result limits.
    localparam int DIST_MAX  = 16777215;
    localparam int KEY_UNDEF = DIST_MAX + 1;
    localparam int HIT_MAX   = 8388607;
    localparam int HIT_MIN   = -8388608;
    localparam int SQ_ITERS  = KEY_W;

    // Item kinds and map codes.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;
    localparam logic [1:0] CELL_EMPTY = 2'd0;

    // Configuration register indexes.
    localparam logic [1:0] REG_PLAYER_X  = 2'd0;
    localparam logic [1:0] REG_PLAYER_Y  = 2'd1;
    localparam logic [1:0] REG_MAX_STEPS = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [5:0]  cell_col;
        logic [5:0]  cell_row;
        logic [1:0]  cell_code;
        logic [11:0] angle;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] hit_x;
        logic signed [23:0] hit_y;
        logic [23:0]        distance;
        logic               hit_side;
    } t_out_item;

    typedef struct packed {
        logic [19:0] player_x;
        logic [19:0] player_y;
        logic [6:0]  max_steps;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NONE, OP_WRITE, OP_LOAD, OP_CORDIC, OP_CFIN, OP_SETUP, OP_MUL,
        OP_DIVA, OP_TAKEA, OP_DIVB, OP_TAKEB, OP_CHECK, OP_DIFF, OP_SQX,
        OP_SQY, OP_SQST, OP_SQRT, OP_KEY, OP_NEXT, OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic cordic_last;
        logic skip;
        logic div_busy;
        logic probe_end;
        logic cell_stop;
        logic sqrt_last;
        logic walk;
    } t_dp_sts;

    // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn.
    function automatic logic signed [CORDIC_W-1:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            default: v = 32'h0;
        endcase
        return $signed(CORDIC_W'(v));
    endfunction

    // Saturate a position to the signed 24-bit result range.
    function automatic logic signed [23:0] sat_hit(input logic signed [POS_W-1:0] v);
        logic signed [POS_W-1:0] hi;
        logic signed [POS_W-1:0] lo;
        hi = POS_W'(HIT_MAX);
        lo = POS_W'(HIT_MIN);
        if (v > hi) begin
            return hi[23:0];
        end else if (v < lo) begin
            return lo[23:0];
        end
        return v[23:0];
    endfunction

endpackage

>>> hw/rtl/grid_ray_caster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid ray caster
// Casts rays over a stored cell map and returns the nearest wall hit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_stall    t_in_item (map write or cast)
//  out       output     o_out_valid / i_out_stall  t_out_item (hit and distance)
//  config    input      APB psel/penable/pwrite    player_x, player_y, max_steps
//
//  A map write item is written from the idle state. A cast runs the rotation
//  unit, then per walk two passes of the shared divider, a probe and a check
//  state per map read and a square root. An axis-parallel walk skips the
//  divider, the map reads and the square root.
//  Reset is synchronous and needs no clearing pass; the map is undefined
//  until written. A new item is taken while a result waits in the output
//  register.
// ----------------------------------------------------------------------------
module grid_ray_caster (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  grc_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output grc_pkg::t_out_item  o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import grc_pkg::*;

    t_cfg    r_cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    cfg_wr;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.player_x  <= '0;
            r_cfg.player_y  <= '0;
            r_cfg.max_steps <= 7'd25;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_PLAYER_X:  r_cfg.player_x  <= pwdata[19:0];
                REG_PLAYER_Y:  r_cfg.player_y  <= pwdata[19:0];
                REG_MAX_STEPS: r_cfg.max_steps <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PLAYER_X:  prdata = 32'(r_cfg.player_x);
            REG_PLAYER_Y:  prdata = 32'(r_cfg.player_y);
            REG_MAX_STEPS: prdata = 32'(r_cfg.max_steps);
            default:       prdata = '0;
        endcase
    end

    grc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_kind   (i_in_item.kind),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    grc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_item     (i_in_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_item (o_out_item)
    );

endmodule

>>> hw/rtl/grc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid ray caster divider
// Signed restoring divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module grc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [grc_pkg::DIV_W-1:0]  i_dividend,
    input  logic signed [grc_pkg::TRIG_W-1:0] i_divisor,
    output logic                              o_busy,
    output logic signed [grc_pkg::DIV_W-1:0]  o_quotient
);
    import grc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_W-1:0]   r_q;
    logic [TRIG_W-1:0]  r_rem;
    logic [TRIG_W-1:0]  r_dvs;
    logic               r_neg;
    logic [TRIG_W:0]    rem_sh;
    logic               ge;

    // One trial subtraction per cycle.
    assign rem_sh = {r_rem, r_q[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CNT_W'(DIV_W - 1)) begin
            r_busy <= 1'b0;
        end
    end

    // Magnitudes are divided; the sign is put back on the quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend[DIV_W-1] ? DIV_W'(-i_dividend) : DIV_W'(i_dividend);
            r_dvs <= i_divisor[TRIG_W-1] ? TRIG_W'(-i_divisor) : TRIG_W'(i_divisor);
            r_neg <= i_dividend[DIV_W-1] ^ i_divisor[TRIG_W-1];
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? TRIG_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[TRIG_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

>>> hw/rtl/grc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid ray caster datapath
// Map store, rotation unit, intercept setup, cell walk, distance and result.
// ----------------------------------------------------------------------------
module grc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  grc_pkg::t_cfg       i_cfg,
    input  grc_pkg::t_in_item   i_item,
    input  grc_pkg::t_dp_cmd    i_cmd,
    output grc_pkg::t_dp_sts    o_sts,
    output grc_pkg::t_out_item  o_out_item
);
    import grc_pkg::*;

    // Map store.
    logic [1:0]  r_map [0:MAP_DIM*MAP_DIM-1];
    logic [1:0]  r_rd;

    // Rotation unit.
    logic signed [CORDIC_W-1:0] r_cx, r_cy, r_cz;
    logic [4:0]                 r_it;
    logic                       r_axis;
    logic [1:0]                 r_quad;
    logic signed [TRIG_W-1:0]   r_c, r_s;

    // Walk state.
    logic                       r_walk;
    logic signed [POS_W-1:0]    r_pa, r_pb, r_sa, r_sb;
    logic signed [DIFF_W-1:0]   r_diff;
    logic signed [DIV_W-1:0]    r_prod;
    logic [6:0]                 r_cnt;

    // Distance.
    logic [23:0]                r_dx, r_dy;
    logic                       r_over;
    logic [47:0]                r_sqx, r_sqy;
    logic [RAD_W-1:0]           r_rad;
    logic [KEY_W-1:0]           r_root;
    logic [REM_W-1:0]           r_rem;
    logic [4:0]                 r_sit;

    // Per-walk results.
    logic signed [POS_W-1:0]    r_vx, r_vy, r_hx, r_hy;
    logic [KEY_W-1:0]           r_vkey, r_hkey;
    t_out_item                  r_out;

    // Combinational helpers.
    logic signed [CORDIC_W-1:0] cd_dx, cd_dy, cd_atan, cl_x, cl_y, q30;
    logic signed [TRIG_W-1:0]   den, num;
    logic                       den_pos;
    logic [19:0]                p_pri, p_sec;
    logic signed [POS_W-1:0]    p_pri_s, p_sec_s, base, start_a;
    logic signed [DIV_W-1:0]    stp_dvd, div_dvd;
    logic signed [DIV_W-1:0]    quot;
    logic                       div_start, div_busy;
    logic signed [POS_W-1:0]    cur_x, cur_y;
    logic                       oob;
    logic [ADDR_W-1:0]          probe_addr;
    logic signed [DD_W-1:0]     dd_x, dd_y;
    logic [DD_W-1:0]            mag_x, mag_y;
    logic [REM_W+1:0]           rem_sh, trial;
    logic                       sq_ge;
    logic [KEY_W-1:0]           key;
    logic                       take_h;

    // Rotation step: shifts by the iteration index.
    assign q30     = CORDIC_W'(Q30_ONE);
    assign cd_dx   = r_cy >>> r_it;
    assign cd_dy   = r_cx >>> r_it;
    assign cd_atan = atan_entry(r_it);

    always_comb begin
        cl_x = r_cx;
        cl_y = r_cy;
        if (r_axis) begin
            cl_x = q30;
            cl_y = '0;
        end else begin
            if (r_cx[CORDIC_W-1]) cl_x = '0;
            else if (r_cx > q30)  cl_x = q30;
            if (r_cy[CORDIC_W-1]) cl_y = '0;
            else if (r_cy > q30)  cl_y = q30;
        end
    end

    // Vertical walk divides by the cosine, horizontal by the sine.
    assign den     = r_walk ? r_s : r_c;
    assign num     = r_walk ? r_c : r_s;
    assign den_pos = !den[TRIG_W-1];
    assign p_pri   = r_walk ? i_cfg.player_y : i_cfg.player_x;
    assign p_sec   = r_walk ? i_cfg.player_x : i_cfg.player_y;
    assign p_pri_s = $signed(POS_W'(p_pri));
    assign p_sec_s = $signed(POS_W'(p_sec));
    assign base    = $signed(POS_W'(p_pri >> CELL_SHIFT) << CELL_SHIFT);
    assign start_a = den_pos ? base + POS_W'(CELL_PX) : base - POS_W'(1);

    assign stp_dvd   = den_pos ? (DIV_W'(num) <<< CELL_SHIFT)
                               : -(DIV_W'(num) <<< CELL_SHIFT);
    assign div_start = (i_cmd.op == OP_DIVA) || (i_cmd.op == OP_DIVB);
    assign div_dvd   = (i_cmd.op == OP_DIVA) ? r_prod : stp_dvd;

    grc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (den),
        .o_busy     (div_busy),
        .o_quotient (quot)
    );

    // Current intercept and the map cell under it.
    assign cur_x = r_walk ? r_pb : r_pa;
    assign cur_y = r_walk ? r_pa : r_pb;
    assign oob   = cur_x[POS_W-1] || cur_y[POS_W-1]
                || (|cur_x[POS_W-2:CELL_SHIFT+MAP_LOG])
                || (|cur_y[POS_W-2:CELL_SHIFT+MAP_LOG]);
    assign probe_addr = {cur_y[CELL_SHIFT+MAP_LOG-1:CELL_SHIFT],
                         cur_x[CELL_SHIFT+MAP_LOG-1:CELL_SHIFT]};

    // Offsets from the player.
    assign dd_x  = DD_W'(cur_x) - $signed(DD_W'(i_cfg.player_x));
    assign dd_y  = DD_W'(cur_y) - $signed(DD_W'(i_cfg.player_y));
    assign mag_x = dd_x[DD_W-1] ? DD_W'(-dd_x) : DD_W'(dd_x);
    assign mag_y = dd_y[DD_W-1] ? DD_W'(-dd_y) : DD_W'(dd_y);

    // Square root: one result bit a cycle.
    assign rem_sh = {r_rem, r_rad[RAD_W-1:RAD_W-2]};
    assign trial  = (REM_W+2)'({r_root, 2'b01});
    assign sq_ge  = rem_sh >= trial;
    assign key    = r_over ? KEY_W'(DIST_MAX)
                  : (r_root > KEY_W'(DIST_MAX) ? KEY_W'(DIST_MAX) : r_root);
    assign take_h = r_hkey < r_vkey;

    // Map store: written by map items, read every cycle at the intercept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WRITE) begin
            r_map[{i_item.cell_row, i_item.cell_col}] <= i_item.cell_code;
        end
        r_rd <= r_map[probe_addr];
    end

    // Sequenced arithmetic.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_quad <= i_item.angle[ANGLE_BITS-1:ANGLE_BITS-2];
                r_axis <= i_item.angle[ANGLE_BITS-3:0] == '0;
                r_cx   <= CORDIC_W'(CORDIC_GAIN);
                r_cy   <= '0;
                r_cz   <= $signed(CORDIC_W'(i_item.angle[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS));
                r_it   <= '0;
                r_walk <= 1'b0;
            end
            OP_CORDIC: begin
                if (!r_axis) begin
                    if (!r_cz[CORDIC_W-1]) begin
                        r_cx <= r_cx - cd_dx;
                        r_cy <= r_cy + cd_dy;
                        r_cz <= r_cz - cd_atan;
                    end else begin
                        r_cx <= r_cx + cd_dx;
                        r_cy <= r_cy - cd_dy;
                        r_cz <= r_cz + cd_atan;
                    end
                end
                r_it <= r_it + 1'b1;
            end
            OP_CFIN: begin
                unique case (r_quad)
                    2'd0: begin r_c <= TRIG_W'(cl_x);  r_s <= TRIG_W'(cl_y);  end
                    2'd1: begin r_c <= TRIG_W'(-cl_y); r_s <= TRIG_W'(cl_x);  end
                    2'd2: begin r_c <= TRIG_W'(-cl_x); r_s <= TRIG_W'(-cl_y); end
                    2'd3: begin r_c <= TRIG_W'(cl_y);  r_s <= TRIG_W'(-cl_x); end
                    default: begin r_c <= '0; r_s <= '0; end
                endcase
            end
            OP_SETUP: begin
                if (den == '0) begin
                    // An axis-parallel walk reports the player and never wins.
                    if (r_walk) begin
                        r_hx   <= $signed(POS_W'(i_cfg.player_x));
                        r_hy   <= $signed(POS_W'(i_cfg.player_y));
                        r_hkey <= KEY_W'(KEY_UNDEF);
                    end else begin
                        r_vx   <= $signed(POS_W'(i_cfg.player_x));
                        r_vy   <= $signed(POS_W'(i_cfg.player_y));
                        r_vkey <= KEY_W'(KEY_UNDEF);
                    end
                end else begin
                    r_pa   <= start_a;
                    r_diff <= DIFF_W'(start_a - p_pri_s);
                end
            end
            OP_MUL:   r_prod <= r_diff * num;
            OP_TAKEA: r_pb   <= p_sec_s + POS_W'(quot);
            OP_TAKEB: begin
                r_sb  <= POS_W'(quot);
                r_sa  <= den_pos ? POS_W'(CELL_PX) : -POS_W'(CELL_PX);
                r_cnt <= '0;
            end
            OP_CHECK: begin
                if (r_rd == CELL_EMPTY) begin
                    r_pa  <= r_pa + r_sa;
                    r_pb  <= r_pb + r_sb;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            OP_DIFF: begin
                r_dx   <= mag_x[23:0];
                r_dy   <= mag_y[23:0];
                r_over <= (mag_x > DD_W'(DIST_MAX)) || (mag_y > DD_W'(DIST_MAX));
            end
            OP_SQX: r_sqx <= r_dx * r_dx;
            OP_SQY: r_sqy <= r_dy * r_dy;
            OP_SQST: begin
                r_rad  <= RAD_W'({1'b0, r_sqx} + {1'b0, r_sqy});
                r_root <= '0;
                r_rem  <= '0;
                r_sit  <= '0;
            end
            OP_SQRT: begin
                r_rem  <= sq_ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
                r_root <= {r_root[KEY_W-2:0], sq_ge};
                r_rad  <= r_rad << 2;
                r_sit  <= r_sit + 1'b1;
            end
            OP_KEY: begin
                if (r_walk) begin
                    r_hx <= cur_x; r_hy <= cur_y; r_hkey <= key;
                end else begin
                    r_vx <= cur_x; r_vy <= cur_y; r_vkey <= key;
                end
            end
            OP_NEXT: r_walk <= 1'b1;
            OP_OUT: begin
                // Ties go to the vertical hit.
                r_out.hit_x    <= sat_hit(take_h ? r_hx : r_vx);
                r_out.hit_y    <= sat_hit(take_h ? r_hy : r_vy);
                r_out.distance <= (take_h ? r_hkey : r_vkey) > KEY_W'(DIST_MAX)
                                ? 24'(DIST_MAX) : (take_h ? r_hkey[23:0] : r_vkey[23:0]);
                r_out.hit_side <= take_h;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.cordic_last = r_it == 5'(CORDIC_ITERS - 1);
    assign o_sts.skip        = den == '0;
    assign o_sts.div_busy    = div_busy;
    assign o_sts.probe_end   = (r_cnt >= i_cfg.max_steps) || oob;
    assign o_sts.cell_stop   = r_rd != CELL_EMPTY;
    assign o_sts.sqrt_last   = r_sit == 5'(SQ_ITERS - 1);
    assign o_sts.walk        = r_walk;
    assign o_out_item        = r_out;

    // A cell is only checked while the step budget lasts.
    a_check_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_CHECK) |-> (r_cnt < i_cfg.max_steps))
        else $error("cell checked after the step budget was spent");

endmodule

>>> hw/rtl/grc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid ray caster controller
// Issues map writes and runs a cast: rotation, two walks, distances, result.
// ----------------------------------------------------------------------------
module grc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    input  logic              i_out_stall,
    input  grc_pkg::t_dp_sts  i_sts,
    output grc_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);
    import grc_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE   = 19'b0000000000000000001,
        S_CORDIC = 19'b0000000000000000010,
        S_CFIN   = 19'b0000000000000000100,
        S_SETUP  = 19'b0000000000000001000,
        S_MUL    = 19'b0000000000000010000,
        S_DIVA   = 19'b0000000000000100000,
        S_WAITA  = 19'b0000000000001000000,
        S_DIVB   = 19'b0000000000010000000,
        S_WAITB  = 19'b0000000000100000000,
        S_PROBE  = 19'b0000000001000000000,
        S_CHECK  = 19'b0000000010000000000,
        S_DIFF   = 19'b0000000100000000000,
        S_SQX    = 19'b0000001000000000000,
        S_SQY    = 19'b0000010000000000000,
        S_SQST   = 19'b0000100000000000000,
        S_SQRT   = 19'b0001000000000000000,
        S_KEY    = 19'b0010000000000000000,
        S_NEXT   = 19'b0100000000000000000,
        S_OUT    = 19'b1000000000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Next state and command.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd.op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_kind == KIND_CAST) begin
                        o_cmd.op = OP_LOAD;
                        n_state  = S_CORDIC;
                    end else begin
                        o_cmd.op = OP_WRITE;
                    end
                end
            end
            S_CORDIC: begin
                o_cmd.op = OP_CORDIC;
                if (i_sts.cordic_last) n_state = S_CFIN;
            end
            S_CFIN: begin
                o_cmd.op = OP_CFIN;
                n_state  = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.op = OP_SETUP;
                n_state  = i_sts.skip ? S_NEXT : S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_DIVA;
            end
            S_DIVA: begin
                o_cmd.op = OP_DIVA;
                n_state  = S_WAITA;
            end
            S_WAITA: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = OP_TAKEA;
                    n_state  = S_DIVB;
                end
            end
            S_DIVB: begin
                o_cmd.op = OP_DIVB;
                n_state  = S_WAITB;
            end
            S_WAITB: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = OP_TAKEB;
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                n_state = i_sts.probe_end ? S_DIFF : S_CHECK;
            end
            S_CHECK: begin
                o_cmd.op = OP_CHECK;
                n_state  = i_sts.cell_stop ? S_DIFF : S_PROBE;
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_SQX;
            end
            S_SQX: begin
                o_cmd.op = OP_SQX;
                n_state  = S_SQY;
            end
            S_SQY: begin
                o_cmd.op = OP_SQY;
                n_state  = S_SQST;
            end
            S_SQST: begin
                o_cmd.op = OP_SQST;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (i_sts.sqrt_last) n_state = S_KEY;
            end
            S_KEY: begin
                o_cmd.op = OP_KEY;
                n_state  = S_NEXT;
            end
            S_NEXT: begin
                if (i_sts.walk) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = OP_NEXT;
                    n_state  = S_SETUP;
                end
            end
            S_OUT: begin
                // Wait for the output register to be free.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_busy |-> (r_state == S_WAITA || r_state == S_WAITB))
        else $error("divider busy outside a wait state");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output state");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && i_out_stall)
        |=> (r_state == S_OUT && r_out_valid))
        else $error("pending result overwritten");

endmodule
